[src/first_free_slot_allocator_macros.svh]
// assertion macros for the first-fit slot allocator
// used by first_free_slot_allocator.sv; expects clk and rst_n in scope
`ifndef FIRST_FREE_SLOT_ALLOCATOR_MACROS_SVH
`define FIRST_FREE_SLOT_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffsa assertion failed");
`define FFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffsa assertion failed");
`else
`define FFSA_ASSERT_IMPL(label, ante, cons)
`define FFSA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/ffsa_pkg.sv]
// shared types, codes and helpers for the first-fit slot allocator
// no dependencies
package ffsa_pkg;

  localparam int ROW_BITS = 32;
  localparam int BIT_W    = 5;
  localparam int CFG_W    = 9;
  localparam int SLOTN_W  = 9;
  localparam int ID_W     = 16;

  typedef logic [ROW_BITS-1:0] row_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_COUNT   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // lowest clear bit of a row
  function automatic logic [BIT_W-1:0] first_zero(row_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

[src/ffsa_owner_mem.sv]
// owner tag memory, one write port and one registered read port
// depends on nothing
module ffsa_owner_mem #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/ffsa_occ_map.sv]
// occupancy map: rows of 32 slot bits in a memory plus a per-row free flag
// depends on ffsa_pkg
module ffsa_occ_map
  import ffsa_pkg::*;
#(
  parameter int ROWS  = 8,
  parameter int ROW_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [ROW_W-1:0] rd_row,
  output row_t             rd_data,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] wr_row,
  input  row_t             wr_data,
  output logic [ROW_W-1:0] first_row,
  output logic             any_avail
);

  row_t           mem [ROWS];
  row_t           rd_data_r;
  logic [ROWS-1:0] avail_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= '0;
    end else if (wr_en) begin
      avail_r[wr_row] <= (wr_data != '1);
    end
  end

  always_comb begin
    first_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (avail_r[i]) begin
        first_row = ROW_W'(i);
      end
    end
  end

  assign any_avail = |avail_r;
  assign rd_data   = rd_data_r;

endmodule

[src/first_free_slot_allocator.sv]
// first-fit slot allocator with owner tags: control, result register, clear sweep
// depends on ffsa_pkg, ffsa_occ_map, ffsa_owner_mem, first_free_slot_allocator_macros.svh
//
// channel  dir  handshake              payload
// in       in   in_tvalid/in_tready    tuser: cmd; tdata: owner_id, slot_number
// out      out  out_tvalid/out_tready  tuser: error; tdata: granted_slot, owner_out, free_count
// cfg      in   cfg_wen                cfg_wdata: slot_count
//
// each word passes row read, update and write-back, and result; no new word is taken before that.
// the pace is set by the occupancy row read and its write-back.
// after reset and after each cfg write a clear sweep over all ceil(MAX_SLOTS/32) rows
// (8 at the default) runs with in_tready low.
// a finished result waits in the output register; the next word is taken meanwhile.
`include "first_free_slot_allocator_macros.svh"

module first_free_slot_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SLOTS  = 256,
  parameter int OWNER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [31:0] in_tdata,   // owner_id, slot_number, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,  // error
  output logic [39:0] out_tdata,  // granted_slot, owner_out, free_count, zero fill
  input  logic        cfg_wen,
  input  logic [8:0]  cfg_wdata   // slot_count
);

  localparam int ROWS   = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = ROW_W + BIT_W;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      slot_count_r, slot_count_nxt;
  logic [CFG_W-1:0]      free_total_r, free_total_nxt;
  logic [ROW_W-1:0]      clr_row_r, clr_row_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [OWNER_BITS-1:0] id_r, id_nxt;
  logic [IDX_W-1:0]      sidx_r, sidx_nxt;
  logic                  in_range_r, in_range_nxt;
  logic [ROW_W-1:0]      op_row_r, op_row_nxt;
  logic                  res_err_r, res_err_nxt;
  logic [SLOTN_W-1:0]    res_granted_r, res_granted_nxt;
  logic [ID_W-1:0]       res_owner_r, res_owner_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_err_r, out_err_nxt;
  logic [SLOTN_W-1:0]    out_granted_r, out_granted_nxt;
  logic [ID_W-1:0]       out_owner_r, out_owner_nxt;
  logic [CFG_W-1:0]      out_free_r, out_free_nxt;

  logic                  occ_rd_en;
  logic [ROW_W-1:0]      occ_rd_row;
  row_t                  occ_rd_data;
  logic                  occ_wr_en;
  logic [ROW_W-1:0]      occ_wr_row;
  row_t                  occ_wr_data;
  logic [ROW_W-1:0]      first_row;
  logic                  any_avail;

  logic                  own_wr_en;
  logic [SLOT_W-1:0]     own_wr_addr;
  logic [SLOT_W-1:0]     own_rd_addr;
  logic [OWNER_BITS-1:0] own_rd_data;

  logic                  accept;
  logic [SLOTN_W-1:0]    in_slot, slot_m1;
  logic [ID_W-1:0]       in_id;
  logic [OWNER_BITS+ID_W-1:0] id_ext, own_ext;
  logic [CFG_W-1:0]      cnt_sat;
  row_t                  clr_word;
  logic [BIT_W-1:0]      zero_pos;
  logic [IDX_W-1:0]      grant_idx;
  logic                  cur_occ;
  logic                  alloc_ok, rel_ok;

  ffsa_occ_map #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_occ (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (occ_rd_en),
    .rd_row    (occ_rd_row),
    .rd_data   (occ_rd_data),
    .wr_en     (occ_wr_en),
    .wr_row    (occ_wr_row),
    .wr_data   (occ_wr_data),
    .first_row (first_row),
    .any_avail (any_avail)
  );

  ffsa_owner_mem #(
    .DEPTH  (MAX_SLOTS),
    .WIDTH  (OWNER_BITS),
    .ADDR_W (SLOT_W)
  ) u_owner (
    .clk     (clk),
    .wr_en   (own_wr_en),
    .wr_addr (own_wr_addr),
    .wr_data (id_r),
    .rd_en   (accept),
    .rd_addr (own_rd_addr),
    .rd_data (own_rd_data)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_id     = in_tdata[15:0];
  assign in_slot   = in_tdata[24:16];
  assign slot_m1   = in_slot - SLOTN_W'(1);
  assign id_ext    = {{OWNER_BITS{1'b0}}, in_id};
  assign own_ext   = {{ID_W{1'b0}}, own_rd_data};
  assign cnt_sat   = (32'(cfg_wdata) > 32'(MAX_SLOTS)) ? CFG_W'(MAX_SLOTS) : cfg_wdata;

  assign occ_rd_en   = accept;
  assign occ_rd_row  = (cmd_t'(in_tuser) == CMD_ALLOC) ? first_row : sidx_nxt[IDX_W-1:BIT_W];
  assign own_rd_addr = SLOT_W'(sidx_nxt);

  // bits at or past the slot count read as taken
  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      clr_word[j] = (32'({clr_row_r, BIT_W'(j)}) >= 32'(slot_count_r));
    end
  end

  assign zero_pos  = first_zero(occ_rd_data);
  assign grant_idx = {op_row_r, zero_pos};
  assign cur_occ   = occ_rd_data[sidx_r[BIT_W-1:0]];
  assign alloc_ok  = (cmd_r == CMD_ALLOC) && (id_r != '0) && (free_total_r != '0)
                     && any_avail && (occ_rd_data != '1);
  assign rel_ok    = (cmd_r == CMD_RELEASE) && in_range_r && cur_occ;

  assign own_wr_en   = (state_r == ST_EXEC) && alloc_ok;
  assign own_wr_addr = SLOT_W'(grant_idx);

  always_comb begin
    occ_wr_en   = 1'b0;
    occ_wr_row  = op_row_r;
    occ_wr_data = occ_rd_data;
    if (state_r == ST_CLEAR) begin
      occ_wr_en   = 1'b1;
      occ_wr_row  = clr_row_r;
      occ_wr_data = clr_word;
    end else if (state_r == ST_EXEC) begin
      if (alloc_ok) begin
        occ_wr_en   = 1'b1;
        occ_wr_data = occ_rd_data | (row_t'(1) << zero_pos);
      end else if (rel_ok) begin
        occ_wr_en   = 1'b1;
        occ_wr_data = occ_rd_data & ~(row_t'(1) << sidx_r[BIT_W-1:0]);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    slot_count_nxt  = slot_count_r;
    free_total_nxt  = free_total_r;
    clr_row_nxt     = clr_row_r;
    cmd_nxt         = cmd_r;
    id_nxt          = id_r;
    sidx_nxt        = IDX_W'(slot_m1);
    in_range_nxt    = in_range_r;
    op_row_nxt      = op_row_r;
    res_err_nxt     = res_err_r;
    res_granted_nxt = res_granted_r;
    res_owner_nxt   = res_owner_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_err_nxt     = out_err_r;
    out_granted_nxt = out_granted_r;
    out_owner_nxt   = out_owner_r;
    out_free_nxt    = out_free_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt      = cmd_t'(in_tuser);
          id_nxt       = id_ext[OWNER_BITS-1:0];
          in_range_nxt = (in_slot != '0) && (in_slot <= slot_count_r);
          op_row_nxt   = occ_rd_row;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_err_nxt     = 1'b0;
        res_granted_nxt = '0;
        res_owner_nxt   = '0;
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (alloc_ok) begin
              res_granted_nxt = SLOTN_W'(grant_idx) + SLOTN_W'(1);
              free_total_nxt  = free_total_r - CFG_W'(1);
            end else begin
              res_err_nxt = 1'b1;
            end
          end
          CMD_RELEASE: begin
            if (rel_ok) begin
              res_owner_nxt  = own_ext[ID_W-1:0];
              free_total_nxt = free_total_r + CFG_W'(1);
            end else begin
              res_err_nxt = 1'b1;
            end
          end
          CMD_QUERY: begin
            if (!in_range_r) begin
              res_err_nxt = 1'b1;
            end else if (cur_occ) begin
              res_owner_nxt = own_ext[ID_W-1:0];
            end
          end
          CMD_COUNT: begin
            res_err_nxt = 1'b0;
          end
        endcase
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_err_nxt     = res_err_r;
          out_granted_nxt = res_granted_r;
          out_owner_nxt   = res_owner_r;
          out_free_nxt    = free_total_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_row_nxt = '0;
      end
    endcase

    if (cfg_wen) begin
      slot_count_nxt = cnt_sat;
      free_total_nxt = cnt_sat;
      clr_row_nxt    = '0;
      state_nxt      = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      slot_count_r <= '0;
      free_total_r <= '0;
      clr_row_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      free_total_r <= free_total_nxt;
      clr_row_r    <= clr_row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    id_r          <= id_nxt;
    sidx_r        <= accept ? sidx_nxt : sidx_r;
    in_range_r    <= in_range_nxt;
    op_row_r      <= op_row_nxt;
    res_err_r     <= res_err_nxt;
    res_granted_r <= res_granted_nxt;
    res_owner_r   <= res_owner_nxt;
    out_err_r     <= out_err_nxt;
    out_granted_r <= out_granted_nxt;
    out_owner_r   <= out_owner_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_err_r;
  assign out_tdata  = {6'd0, out_free_r, out_owner_r, out_granted_r};

  `FFSA_ASSERT_IMPL(a_free_le_count, 1'b1, free_total_r <= slot_count_r)
  `FFSA_ASSERT_IMPL(a_no_take_in_clear, state_r == ST_CLEAR, !in_tready)
  `FFSA_ASSERT_IMPL(a_grant_in_range, out_tvalid && (out_granted_r != '0), !out_err_r && (out_granted_r <= slot_count_r))
  `FFSA_ASSERT_NEXT(a_alloc_takes_one, (state_r == ST_EXEC) && alloc_ok && !cfg_wen, free_total_r == $past(free_total_r) - CFG_W'(1))

endmodule

[bench/tb_top.sv]
// self-checking bench for first_free_slot_allocator: random and directed slot commands
// checks every reply word against an in-bench allocator model, across several slot counts
// depends on ffsa_pkg and the allocator rtl
`timescale 1ns / 100ps

module tb_top;
  import ffsa_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    cmd_t        op;
    logic [15:0] owner_id;
    logic [8:0]  slot;
  } slot_cmd_t;

  typedef struct packed {
    logic        err;
    logic [8:0]  granted;
    logic [15:0] owner;
    logic [8:0]  free;
  } slot_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;   // cmd
  logic [31:0] in_tdata = '0;   // owner_id, slot_number, zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [0:0]  out_tuser;       // error
  logic [39:0] out_tdata;       // granted_slot, owner_out, free_count, zero fill
  logic        cfg_wen = 1'b0;
  logic [8:0]  cfg_wdata = '0;  // slot_count

  first_free_slot_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // allocator model state
  logic [15:0] mdl_owner [TABLE_DEPTH];
  bit          mdl_busy  [TABLE_DEPTH];
  int          mdl_slots;
  int          mdl_free;

  slot_cmd_t   cmd_backlog[$];
  slot_reply_t reply_backlog[$];
  int          words_queued = 0;
  int          words_taken = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          tx_gap = 0;
  int          rx_stall = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_model(int slots);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      mdl_owner[i] = '0;
      mdl_busy[i]  = 1'b0;
    end
    mdl_slots = slots;
    mdl_free  = slots;
  endfunction

  function automatic slot_reply_t apply_slot_cmd(cmd_t op, logic [15:0] id, logic [8:0] slot);
    slot_reply_t r;
    bit          in_rng;
    r = '0;
    in_rng = (slot >= 1) && (int'(slot) <= mdl_slots);
    case (op)
      CMD_ALLOC: begin
        if (id != 0 && mdl_free != 0) begin
          for (int i = 0; i < mdl_slots; i++) begin
            if (!mdl_busy[i]) begin
              mdl_busy[i]  = 1'b1;
              mdl_owner[i] = id;
              mdl_free--;
              r.granted = 9'(i + 1);
              break;
            end
          end
        end
        if (r.granted == 0) r.err = 1'b1;
      end
      CMD_RELEASE: begin
        if (in_rng && mdl_busy[slot-1]) begin
          r.owner = mdl_owner[slot-1];
          mdl_owner[slot-1] = '0;
          mdl_busy[slot-1]  = 1'b0;
          mdl_free++;
        end else begin
          r.err = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (in_rng) r.owner = mdl_busy[slot-1] ? mdl_owner[slot-1] : 16'h0000;
        else r.err = 1'b1;
      end
      default: ;
    endcase
    r.free = 9'(mdl_free);
    return r;
  endfunction

  task automatic report_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // input word driver
  always @(negedge clk) begin
    slot_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog.pop_front();
        in_tuser  <= c.op;
        in_tdata  <= {7'b0, c.slot, c.owner_id};
        in_tvalid <= 1'b1;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // reply side backpressure
  always @(negedge clk) begin
    if (out_taken) rx_stall = rx_burst ? 0 : $urandom_range(0, 16);
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    slot_reply_t want;
    in_taken  <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (reply_backlog.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reply word, expected none, actual %h/%h",
                   $realtime, out_tuser, out_tdata);
        end else begin
          want = reply_backlog.pop_front();
          report_field("error", 16'(want.err), 16'(out_tuser[0]));
          report_field("granted_slot", 16'(want.granted), 16'(out_tdata[8:0]));
          report_field("owner_out", want.owner, out_tdata[24:9]);
          report_field("free_count", 16'(want.free), 16'(out_tdata[33:25]));
        end
      end
      if (in_tvalid && in_tready) begin
        reply_backlog.push_back(apply_slot_cmd(cmd_t'(in_tuser), in_tdata[15:0], in_tdata[24:16]));
        words_taken <= words_taken + 1;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic push_cmd(cmd_t op, logic [15:0] id, logic [8:0] slot);
    slot_cmd_t c;
    c.op = op;
    c.owner_id = id;
    c.slot = slot;
    cmd_backlog.push_back(c);
    words_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (words_taken != words_queued || reply_backlog.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_slot_count(logic [8:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_wen   <= 1'b1;
    clear_model((value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value));
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_random(int n, int alloc_pct);
    int   r;
    cmd_t op;
    logic [15:0] id;
    logic [8:0]  slot;
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) op = CMD_ALLOC;
      else begin
        r = $urandom_range(0, 99);
        if (r < 45) op = CMD_RELEASE;
        else if (r < 80) op = CMD_QUERY;
        else op = CMD_COUNT;
      end
      r = $urandom_range(0, 99);
      if (r < 5) id = 16'h0000;
      else if (r < 10) id = 16'hFFFF;
      else id = 16'($urandom_range(1, 65535));
      r = $urandom_range(0, 99);
      if (r < 80 && mdl_slots > 0) slot = 9'($urandom_range(1, mdl_slots));
      else if (r < 85) slot = 9'd0;
      else slot = 9'($urandom_range(0, 511));
      push_cmd(op, id, slot);
    end
  endtask

  initial begin
    clear_model(0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_slot_count(9'd4);
    push_cmd(CMD_COUNT,   16'h0000, 9'd0);
    push_cmd(CMD_QUERY,   16'h0000, 9'd0);
    push_cmd(CMD_QUERY,   16'h0000, 9'd5);
    push_cmd(CMD_ALLOC,   16'h0000, 9'd0);
    push_cmd(CMD_ALLOC,   16'hFFFF, 9'd0);
    push_cmd(CMD_ALLOC,   16'h0001, 9'd511);
    push_cmd(CMD_ALLOC,   16'h8001, 9'd0);
    push_cmd(CMD_ALLOC,   16'h1234, 9'd0);
    push_cmd(CMD_ALLOC,   16'h5555, 9'd0);
    push_cmd(CMD_QUERY,   16'h0000, 9'd1);
    push_cmd(CMD_QUERY,   16'hFFFF, 9'd4);
    push_cmd(CMD_QUERY,   16'h0000, 9'd511);
    push_cmd(CMD_RELEASE, 16'h0000, 9'd0);
    push_cmd(CMD_RELEASE, 16'h0000, 9'd5);
    push_cmd(CMD_RELEASE, 16'h0000, 9'd2);
    push_cmd(CMD_RELEASE, 16'h0000, 9'd2);
    push_cmd(CMD_QUERY,   16'h0000, 9'd2);
    push_cmd(CMD_ALLOC,   16'hAAAA, 9'd0);
    push_cmd(CMD_RELEASE, 16'hFFFF, 9'd256);

    write_slot_count(9'd0);
    push_cmd(CMD_ALLOC,   16'h0007, 9'd1);
    push_cmd(CMD_RELEASE, 16'h0000, 9'd1);
    push_cmd(CMD_QUERY,   16'h0000, 9'd1);
    push_cmd(CMD_COUNT,   16'h0000, 9'd0);
    push_random(20, 40);

    write_slot_count(9'd256);
    push_random(350, 75);
    write_slot_count(9'd511);
    push_random(100, 40);
    write_slot_count(9'd1);
    push_random(100, 40);
    write_slot_count(9'd300);
    push_random(100, 50);
    write_slot_count(9'd16);
    push_random(250, 45);
    write_slot_count(9'd255);
    push_random(150, 60);
    write_slot_count(9'($urandom_range(2, 40)));
    push_random(100, 40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && reply_backlog.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ffsa_pkg.sv
src/ffsa_owner_mem.sv
src/ffsa_occ_map.sv
src/first_free_slot_allocator.sv
bench/tb_top.sv
